@@ rtl/bxavg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bxavg_pkg: shared constants and types of the box average downscaler
// Field widths, register indexes, controller/datapath command and status.
// ----------------------------------------------------------------------------
package bxavg_pkg;

  // Sizing
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_FACTOR = 16;
  localparam int MAX_HEIGHT = 4096;

  // Fixed field and register widths
  localparam int PIX_W    = 8;
  localparam int CFG_W    = 13;
  localparam int CFG_F_W  = 5;
  localparam int CFG_IDX_W = 2;

  // Derived widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int BLK_W  = $clog2(MAX_FACTOR);
  localparam int SUM_W  = PIX_W + 2 * BLK_W;
  localparam int DIV_W  = 2 * BLK_W + 1;
  localparam int QUO_W  = PIX_W;
  localparam int STEP_W = $clog2(QUO_W);
  localparam int NUM_CH = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 2'd2;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } bxavg_state_e;

  typedef struct packed {
    logic capture;   // take pixel, read column sum, advance position
    logic update;    // accumulate, write back, load divider
    logic div_step;  // one quotient bit
    logic out_load;  // move averages to output register
  } bxavg_cmd_t;

  typedef struct packed {
    logic emit;      // captured pixel closes a block
    logic out_free;  // output register can take a result this cycle
  } bxavg_stat_t;

endpackage
`default_nettype wire

@@ rtl/bxavg_pix_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bxavg_pix_if: input pixel channel
// Valid/ready handshake carrying one RGB pixel.
// ----------------------------------------------------------------------------
interface bxavg_pix_if import bxavg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] in_red;
  logic [PIX_W-1:0] in_green;
  logic [PIX_W-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/bxavg_avg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bxavg_avg_if: output block average channel
// Valid/ready handshake carrying one averaged block and a frame end flag.
// ----------------------------------------------------------------------------
interface bxavg_avg_if import bxavg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] avg_red;
  logic [PIX_W-1:0] avg_green;
  logic [PIX_W-1:0] avg_blue;
  logic             frame_end;

  modport source (output valid, output avg_red, output avg_green, output avg_blue,
                  output frame_end, input ready);
  modport sink   (input valid, input avg_red, input avg_green, input avg_blue,
                  input frame_end, output ready);
endinterface
`default_nettype wire

@@ rtl/bxavg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bxavg_ctrl: sequencing state machine
// Steps each pixel through capture and accumulate, a block-closing pixel also through divide and output load.
// ----------------------------------------------------------------------------
module bxavg_ctrl import bxavg_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        pix_valid_i,
  output logic             pix_ready_o,
  input  wire bxavg_stat_t stat_i,
  output bxavg_cmd_t       cmd_o
);

  bxavg_state_e            state_q, state_d;
  logic [STEP_W-1:0]       step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (pix_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.update = 1'b1;
        step_d       = '0;
        state_d      = stat_i.emit ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_W'(1);
        if (step_q == STEP_W'(QUO_W - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign pix_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/bxavg_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bxavg_dp: downscaler datapath
// Config registers, position counters, column sum memory, bit-serial
// divider by factor squared and the output register.
// ----------------------------------------------------------------------------
module bxavg_dp import bxavg_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic [PIX_W-1:0]     pix_red_i,
  input  wire logic [PIX_W-1:0]     pix_green_i,
  input  wire logic [PIX_W-1:0]     pix_blue_i,
  input  wire bxavg_cmd_t           cmd_i,
  output bxavg_stat_t               stat_o,
  input  wire logic                 res_ready_i,
  output logic                      res_valid_o,
  output logic [PIX_W-1:0]          res_red_o,
  output logic [PIX_W-1:0]          res_green_o,
  output logic [PIX_W-1:0]          res_blue_o,
  output logic                      res_frame_end_o
);

  // Config
  logic [CFG_W-1:0]   cfg_w_q, cfg_h_q;
  logic [CFG_F_W-1:0] cfg_f_q;
  logic               restart;
  logic [CFG_W-1:0]   w_eff, h_eff;
  logic [CFG_F_W-1:0] f_eff;
  logic [2*CFG_F_W-1:0] f_sq;
  logic [DIV_W-1:0]   d_eff;

  // Position
  logic [COL_W-1:0]   col_q, oc_q;
  logic [ROW_W-1:0]   row_q;
  logic [BLK_W-1:0]   cib_q, rib_q;
  logic               last_col, last_row, cib_wrap, rib_wrap, blk_end, band_end;

  // Captured item
  logic [PIX_W-1:0]          pix_q [NUM_CH];
  logic [NUM_CH*SUM_W-1:0]   rd_q;
  logic [COL_W-1:0]          wa_q;
  logic                      first_q, emit_q, fend_q;
  logic [SUM_W-1:0]          sum [NUM_CH];
  logic [NUM_CH*SUM_W-1:0]   wd;

  // Column sums
  logic [NUM_CH*SUM_W-1:0]   mem [MAX_WIDTH];

  // Divider
  logic [SUM_W-1:0]   rem_q [NUM_CH];
  logic [QUO_W-1:0]   quo_q [NUM_CH];
  logic [SUM_W-1:0]   dsh_q;
  logic               ge [NUM_CH];

  // Output
  logic               res_valid_q;
  logic [PIX_W-1:0]   res_q [NUM_CH];
  logic               res_fend_q;

  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_SCALE_FACTOR: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CFG_W'(640);
      cfg_h_q <= CFG_W'(480);
      cfg_f_q <= CFG_F_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  cfg_w_q <= cfg_data_i;
        CFG_IMAGE_HEIGHT: cfg_h_q <= cfg_data_i;
        CFG_SCALE_FACTOR: cfg_f_q <= cfg_data_i[CFG_F_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero reads as one, oversize saturates
  assign w_eff = (cfg_w_q == '0) ? CFG_W'(1) :
                 (cfg_w_q > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : cfg_w_q;
  assign h_eff = (cfg_h_q == '0) ? CFG_W'(1) :
                 (cfg_h_q > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : cfg_h_q;
  assign f_eff = (cfg_f_q == '0) ? CFG_F_W'(1) :
                 (cfg_f_q > CFG_F_W'(MAX_FACTOR)) ? CFG_F_W'(MAX_FACTOR) : cfg_f_q;
  assign f_sq  = f_eff * f_eff;
  assign d_eff = f_sq[DIV_W-1:0];

  assign last_col = (CFG_W'(col_q) + CFG_W'(1)) >= w_eff;
  assign last_row = (CFG_W'(row_q) + CFG_W'(1)) >= h_eff;
  assign cib_wrap = (CFG_F_W'(cib_q) + CFG_F_W'(1)) >= f_eff;
  assign rib_wrap = (CFG_F_W'(rib_q) + CFG_F_W'(1)) >= f_eff;
  assign blk_end  = last_col || cib_wrap;
  assign band_end = last_row || rib_wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      oc_q  <= '0;
      cib_q <= '0;
      rib_q <= '0;
    end else if (restart) begin
      col_q <= '0;
      row_q <= '0;
      oc_q  <= '0;
      cib_q <= '0;
      rib_q <= '0;
    end else if (cmd_i.capture) begin
      if (last_col) begin
        col_q <= '0;
        oc_q  <= '0;
        cib_q <= '0;
        if (last_row) begin
          row_q <= '0;
          rib_q <= '0;
        end else begin
          row_q <= row_q + ROW_W'(1);
          rib_q <= rib_wrap ? '0 : rib_q + BLK_W'(1);
        end
      end else begin
        col_q <= col_q + COL_W'(1);
        if (cib_wrap) begin
          cib_q <= '0;
          oc_q  <= oc_q + COL_W'(1);
        end else begin
          cib_q <= cib_q + BLK_W'(1);
        end
      end
    end
  end

  // Capture pixel and the block flags it raises
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q[0] <= pix_red_i;
      pix_q[1] <= pix_green_i;
      pix_q[2] <= pix_blue_i;
      wa_q     <= oc_q;
      first_q  <= (rib_q == '0) && (cib_q == '0);
      emit_q   <= blk_end && band_end;
      fend_q   <= last_col && last_row;
    end
  end

  // First pixel of a block overwrites its column sum, so stale contents never surface
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum[c] = (first_q ? '0 : rd_q[c*SUM_W +: SUM_W]) + SUM_W'(pix_q[c]);
      wd[c*SUM_W +: SUM_W] = sum[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      mem[wa_q] <= wd;
    end
    if (cmd_i.capture) begin
      rd_q <= mem[oc_q];
    end
  end

  // Restoring divide, one quotient bit per step, all channels in parallel
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      ge[c] = rem_q[c] >= dsh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      for (int c = 0; c < NUM_CH; c++) begin
        rem_q[c] <= sum[c];
      end
      dsh_q <= SUM_W'(d_eff) << (QUO_W - 1);
    end else if (cmd_i.div_step) begin
      for (int c = 0; c < NUM_CH; c++) begin
        rem_q[c] <= ge[c] ? rem_q[c] - dsh_q : rem_q[c];
        quo_q[c] <= {quo_q[c][QUO_W-2:0], ge[c]};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int c = 0; c < NUM_CH; c++) begin
        res_q[c] <= quo_q[c];
      end
      res_fend_q <= fend_q;
    end
  end

  assign stat_o.emit     = emit_q;
  assign stat_o.out_free = !res_valid_q || res_ready_i;

  assign res_valid_o     = res_valid_q;
  assign res_red_o       = res_q[0];
  assign res_green_o     = res_q[1];
  assign res_blue_o      = res_q[2];
  assign res_frame_end_o = res_fend_q;

endmodule
`default_nettype wire

@@ rtl/box_average_downscale.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_average_downscale: integer factor box filter image downscaler
// Averages each channel over scale_factor x scale_factor blocks of a raster
// RGB stream and emits one averaged pixel per block.
//
// Channels: pix_i takes RGB pixels in raster order, res_o gives block
// averages in raster order of blocks; both are valid/ready, a transfer
// happens when valid and ready are high at a rising edge.
// Config: cfg_we_i/cfg_idx_i/cfg_data_i write image width, height and
// scale factor; a write to any of them restarts the frame. Write only while idle.
// Steps: a pixel that closes no block is captured, then read-modify-writes
// its column sum; a pixel that closes a block then also runs the bit-serial
// divide by factor squared and an output load that waits for a free output
// register. pix_i takes no new pixel before the last one is through. The
// output register frees pix_i for the next pixel while the result waits;
// a stalled res_o holds the block only at the next result.
// Reset: registers return to 640 x 480, factor 2, position to frame start;
// the column sum memory needs no clearing pass.
// ----------------------------------------------------------------------------
module box_average_downscale import bxavg_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  bxavg_pix_if.sink                 pix_i,
  bxavg_avg_if.source               res_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  bxavg_cmd_t  cmd;
  bxavg_stat_t stat;
  logic        pix_ready;

  // Sequencer: one pixel in flight at a time
  bxavg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_ready_o (pix_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  assign pix_i.ready = pix_ready;

  // Counters, column sums, divider, output register
  bxavg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .pix_red_i       (pix_i.in_red),
    .pix_green_i     (pix_i.in_green),
    .pix_blue_i      (pix_i.in_blue),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .res_ready_i     (res_o.ready),
    .res_valid_o     (res_o.valid),
    .res_red_o       (res_o.avg_red),
    .res_green_o     (res_o.avg_green),
    .res_blue_o      (res_o.avg_blue),
    .res_frame_end_o (res_o.frame_end)
  );

  // A captured pixel is always followed by its accumulate cycle
  a_capture_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> !pix_i.ready)
    else $error("pixel taken while previous one still accumulating");

  // A pixel that closes no block frees the input right after accumulating
  a_no_emit_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.update && !stat.emit) |=> pix_i.ready)
    else $error("input not freed after non-closing pixel");

  // Never overwrite a result that has not been transferred
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!res_o.valid || res_o.ready))
    else $error("output register overwritten");

  // A new result only appears from an output load
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(cmd.out_load))
    else $error("result valid without output load");

endmodule
`default_nettype wire
